FILE: rtl/rdmc_pkg.sv
// Package with types, constants and CRC-32C helpers for the masked CRC-32C record deframer.
`default_nettype none

package rdmc_pkg;

	localparam int COUNT_BITS = 32;

	localparam logic [31:0] CRC_POLY = 32'h82f63b78;
	localparam logic [31:0] CRC_INIT = 32'hffffffff;
	localparam logic [31:0] MASK_ADD = 32'ha282ead8;
	localparam int          ROT_RIGHT = 15;
	localparam int          ROT_LEFT = 17;
	localparam logic [3:0]  HDR_LEN_BYTES = 4'd8;
	localparam logic [3:0]  HDR_LAST = 4'd11;
	localparam logic [1:0]  TRL_LAST = 2'd3;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_TRAILER = 2'd2,
		PH_STOPPED = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		KIND_PAYLOAD   = 3'd0,
		KIND_OK        = 3'd1,
		KIND_LEN_BAD   = 3'd2,
		KIND_DATA_BAD  = 3'd3,
		KIND_TRUNCATED = 3'd4,
		KIND_CLEAN_END = 3'd5
	} kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		kind_t       kind;
		logic [63:0] record_length;
		logic [31:0] records_done;
	} out_t;

	// One byte of the reflected Castagnoli CRC, bit by bit.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Finalize the CRC register, rotate right and add the mask constant.
	function automatic logic [31:0] crc_masked(input logic [31:0] crc);
		logic [31:0] c;
		logic [31:0] r;
		c = ~crc;
		r = (c >> ROT_RIGHT) | (c << ROT_LEFT);
		return r + MASK_ADD;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/record_deframer_masked_crc32c.sv
// Top level of the masked CRC-32C record deframer: input register, decode logic, result register.
//
// The block takes a byte stream of length-prefixed records on the item channel and
// emits one transaction on the result channel per payload byte, plus one status
// transaction that closes each record. A record is an 8-byte little-endian length,
// a 4-byte masked CRC-32C of those bytes, the payload and a 4-byte masked CRC-32C of
// the payload. Payload bytes leave before the record is verified; the status follows.
// An item with end_of_input set ends the stream: a clean end at a record boundary,
// a truncation report anywhere else.
// Both channels use valid and stall; a transaction completes when valid is high and
// stall is low. An item is taken into the input register, and the decode logic then updates
// the record state and loads the result register once that register is free. So each result
// is offered from the result register, and one item per cycle is sustained while the receiver
// does not stall; the CRC byte update and the 64-bit length counter are combinational.
// When the receiver stalls, the result register holds and the input register fills;
// the item channel stalls only while both are full.
// Asynchronous reset empties both registers and returns the state to the start of a
// record with zero verified records. The end of the stream, clean or truncated, and a
// bad CRC stop the block: all later items are accepted and dropped until the next reset.
`default_nettype none

module record_deframer_masked_crc32c
	import rdmc_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic item_valid,
	output logic       item_stall,
	input  wire  in_t  item,
	output logic       result_valid,
	input  wire  logic result_stall,
	output out_t       result
);

	// Input register.
	logic s1_valid_q;
	in_t  item_s1;

	// Record state.
	phase_t                  phase_q,    phase_d;
	logic [3:0]              hdr_idx_q,  hdr_idx_d;
	logic [63:0]             length_q,   length_d;
	logic [63:0]             left_q,     left_d;
	logic [31:0]             crc_q,      crc_d;
	logic [31:0]             rcv_q,      rcv_d;
	logic [1:0]              trl_idx_q,  trl_idx_d;
	logic [COUNT_BITS-1:0]   count_q,    count_d;

	// Result register.
	logic result_valid_q;
	out_t result_q;

	logic out_free;
	logic advance;
	logic emit;
	out_t res_d;

	// The result register can take a new value when it is empty or being drained.
	assign out_free   = !result_valid_q || !result_stall;
	assign advance    = s1_valid_q && out_free;
	assign item_stall = s1_valid_q && !out_free;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		logic [63:0] len_n;
		logic [31:0] rcv_n;
		logic [31:0] crc_n;
		logic [63:0] left_n;
		logic [63:0] cnt_ext;

		phase_d   = phase_q;
		hdr_idx_d = hdr_idx_q;
		length_d  = length_q;
		left_d    = left_q;
		crc_d     = crc_q;
		rcv_d     = rcv_q;
		trl_idx_d = trl_idx_q;
		count_d   = count_q;
		emit      = 1'b0;
		res_d     = '0;
		len_n     = '0;
		rcv_n     = '0;
		crc_n     = CRC_INIT;
		left_n    = left_q - 64'd1;

		if (phase_q == PH_STOPPED) begin
			emit = 1'b0;
		end else if (item_s1.end_of_input) begin
			emit    = 1'b1;
			phase_d = PH_STOPPED;
			if (phase_q == PH_HEADER && hdr_idx_q == 4'd0) begin
				res_d.kind          = KIND_CLEAN_END;
				res_d.record_length = 64'd0;
			end else begin
				res_d.kind          = KIND_TRUNCATED;
				res_d.record_length = length_q;
			end
		end else begin
			case (phase_q)
				PH_HEADER: begin
					// The first header byte starts a fresh record.
					if (hdr_idx_q != 4'd0) begin
						len_n = length_q;
						rcv_n = rcv_q;
						crc_n = crc_q;
					end
					if (hdr_idx_q < HDR_LEN_BYTES) begin
						len_n[{hdr_idx_q[2:0], 3'b000} +: 8] = item_s1.in_byte;
						crc_n = crc_byte(crc_n, item_s1.in_byte);
					end else begin
						rcv_n[{hdr_idx_q[1:0], 3'b000} +: 8] = item_s1.in_byte;
					end
					length_d  = len_n;
					crc_d     = crc_n;
					rcv_d     = rcv_n;
					hdr_idx_d = hdr_idx_q + 4'd1;
					if (hdr_idx_q == HDR_LAST) begin
						hdr_idx_d = 4'd0;
						if (crc_masked(crc_n) != rcv_n) begin
							emit                = 1'b1;
							res_d.kind          = KIND_LEN_BAD;
							res_d.record_length = len_n;
							phase_d             = PH_STOPPED;
						end else begin
							left_d    = len_n;
							crc_d     = CRC_INIT;
							rcv_d     = 32'd0;
							trl_idx_d = 2'd0;
							phase_d   = (len_n == 64'd0) ? PH_TRAILER : PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					crc_d          = crc_byte(crc_q, item_s1.in_byte);
					left_d         = left_n;
					emit           = 1'b1;
					res_d.kind     = KIND_PAYLOAD;
					res_d.out_byte = item_s1.in_byte;
					if (left_n == 64'd0) begin
						phase_d = PH_TRAILER;
					end
				end
				PH_TRAILER: begin
					rcv_n = rcv_q;
					rcv_n[{trl_idx_q, 3'b000} +: 8] = item_s1.in_byte;
					rcv_d     = rcv_n;
					trl_idx_d = trl_idx_q + 2'd1;
					if (trl_idx_q == TRL_LAST) begin
						emit                = 1'b1;
						res_d.record_length = length_q;
						if (crc_masked(crc_q) != rcv_n) begin
							res_d.kind = KIND_DATA_BAD;
							phase_d    = PH_STOPPED;
						end else begin
							res_d.kind = KIND_OK;
							count_d    = count_q + COUNT_BITS'(1);
							phase_d    = PH_HEADER;
						end
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end

		cnt_ext            = 64'(count_d);
		res_d.records_done = cnt_ext[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q     <= 1'b0;
			result_valid_q <= 1'b0;
			phase_q        <= PH_HEADER;
			hdr_idx_q      <= 4'd0;
			length_q       <= 64'd0;
			left_q         <= 64'd0;
			crc_q          <= CRC_INIT;
			rcv_q          <= 32'd0;
			trl_idx_q      <= 2'd0;
			count_q        <= '0;
		end else begin
			if (item_valid && !item_stall) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (out_free) begin
				result_valid_q <= advance && emit;
			end
			if (advance) begin
				phase_q   <= phase_d;
				hdr_idx_q <= hdr_idx_d;
				length_q  <= length_d;
				left_q    <= left_d;
				crc_q     <= crc_d;
				rcv_q     <= rcv_d;
				trl_idx_q <= trl_idx_d;
				count_q   <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (advance && emit) begin
			result_q <= res_d;
		end
	end

	// Once stopped, only reset brings the block back.
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_STOPPED |=> phase_q == PH_STOPPED)
		else $error("deframer left the stopped phase without reset");

	// While in the payload phase at least one payload byte is still expected.
	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> left_q != 64'd0)
		else $error("payload phase with no bytes left");

	// A verified record advances the record count by exactly one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && res_d.kind == KIND_OK
		|=> count_q == $past(count_q) + COUNT_BITS'(1))
		else $error("record count did not advance on a verified record");

endmodule

`default_nettype wire

FILE: dv/record_deframer_masked_crc32c_tb.sv
// Self-checking testbench for the masked CRC-32C record deframer.
module record_deframer_masked_crc32c_tb;
	import rdmc_pkg::*;

	// Clock, reset and the two channels. Every input is known from time zero.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	in_t  item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_t result;

	record_deframer_masked_crc32c dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The run ends here if the handshakes ever lock up.
	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

	// Percentages of cycles in which the sender holds back and the receiver stalls.
	int unsigned gap_pct = 8;
	int unsigned stall_pct = 48;

	// Results predicted for accepted items, oldest first.
	out_t pending_results[$];
	int unsigned failures = 0;

	// Our own copy of the deframer state, in its reset condition.
	phase_t      ph = PH_HEADER;
	logic [3:0]  hdr_idx = '0;
	logic [63:0] len_acc = '0;
	logic [63:0] remaining = '0;
	logic [31:0] crc_reg = CRC_INIT;
	logic [31:0] crc_rx = '0;
	logic [1:0]  trl_idx = '0;
	logic [31:0] verified = '0;

	// Stream under construction: the payload of the next record and the record framed.
	logic [7:0] payload_bytes[$];
	logic [7:0] frame_bytes[$];

	// Reflected Castagnoli CRC, one data bit at a time, least significant bit first.
	function automatic logic [31:0] crc32c_update(logic [31:0] state, logic [7:0] data);
		logic [31:0] s;
		logic fb;
		s = state;
		for (int i = 0; i < 8; i++) begin
			fb = s[0] ^ data[i];
			s = s >> 1;
			if (fb)
				s = s ^ CRC_POLY;
		end
		return s;
	endfunction

	// Finished CRC rotated right by 15 bits, then offset by the mask constant.
	function automatic logic [31:0] seal(logic [31:0] state);
		logic [31:0] c;
		c = ~state;
		return {c[14:0], c[31:15]} + MASK_ADD;
	endfunction

	function automatic void queue_result(logic [7:0] b, kind_t k, logic [63:0] len);
		out_t r;
		r.out_byte = b;
		r.kind = k;
		r.record_length = len;
		r.records_done = verified;
		pending_results.push_back(r);
	endfunction

	// Advance the predicted state by one accepted item and queue the result it causes.
	function automatic void deframe_step(in_t it);
		logic [7:0] b;
		b = it.in_byte;
		// Once stopped, nothing but a reset brings the block back.
		if (ph == PH_STOPPED)
			return;
		// End of stream: clean only between records, a truncation anywhere else.
		if (it.end_of_input) begin
			if (ph == PH_HEADER && hdr_idx == 0)
				queue_result(8'h00, KIND_CLEAN_END, 64'd0);
			else
				queue_result(8'h00, KIND_TRUNCATED, len_acc);
			ph = PH_STOPPED;
			return;
		end
		case (ph)
			PH_HEADER: begin
				if (hdr_idx == 0) begin
					len_acc = '0;
					crc_rx = '0;
					crc_reg = CRC_INIT;
				end
				if (hdr_idx < HDR_LEN_BYTES) begin
					len_acc[8 * hdr_idx +: 8] = b;
					crc_reg = crc32c_update(crc_reg, b);
				end else begin
					crc_rx[8 * (hdr_idx - 8) +: 8] = b;
				end
				if (hdr_idx == HDR_LAST) begin
					hdr_idx = '0;
					if (seal(crc_reg) != crc_rx) begin
						queue_result(8'h00, KIND_LEN_BAD, len_acc);
						ph = PH_STOPPED;
					end else begin
						remaining = len_acc;
						crc_reg = CRC_INIT;
						crc_rx = '0;
						trl_idx = '0;
						// An empty record goes straight to its trailer.
						ph = (len_acc == 0) ? PH_TRAILER : PH_PAYLOAD;
					end
				end else begin
					hdr_idx++;
				end
			end
			PH_PAYLOAD: begin
				// Payload leaves at once, before the record is verified.
				crc_reg = crc32c_update(crc_reg, b);
				remaining--;
				if (remaining == 0)
					ph = PH_TRAILER;
				queue_result(b, KIND_PAYLOAD, 64'd0);
			end
			PH_TRAILER: begin
				crc_rx[8 * trl_idx +: 8] = b;
				if (trl_idx == TRL_LAST) begin
					trl_idx = '0;
					if (seal(crc_reg) != crc_rx) begin
						queue_result(8'h00, KIND_DATA_BAD, len_acc);
						ph = PH_STOPPED;
					end else begin
						verified++;
						queue_result(8'h00, KIND_OK, len_acc);
						ph = PH_HEADER;
					end
				end else begin
					trl_idx++;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void note_failure(string what, out_t want, out_t got);
		failures++;
		if (failures <= 10)
			$display("%s at %0t: expected byte=%02h kind=%0d len=%016h done=%0d, got byte=%02h kind=%0d len=%016h done=%0d",
				what, $realtime, want.out_byte, want.kind, want.record_length, want.records_done,
				got.out_byte, got.kind, got.record_length, got.records_done);
	endfunction

	// Every item transaction taken by the block feeds the predictor. The values seen
	// here are those from before the edge, so the order of processes does not matter.
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			deframe_step(item);
	end

	// Every result transaction is held against the oldest prediction, field by field.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				note_failure("unexpected result", '0, result);
			end else begin
				want = pending_results.pop_front();
				if (result.out_byte !== want.out_byte || result.kind !== want.kind ||
					result.record_length !== want.record_length ||
					result.records_done !== want.records_done)
					note_failure("result mismatch", want, result);
			end
		end
	end

	// The receiver stalls at random; at zero percent it never stalls.
	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Offer one item and hold it until a transaction takes it. Valid is only dropped
	// in a cycle where the sender decides to hold back, so it is never lowered and
	// raised in the same step.
	task automatic push_stream_byte(logic [7:0] b, logic eoi);
		while ($urandom_range(0, 99) < gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= in_t'{in_byte: b, end_of_input: eoi};
		do
			@(posedge clk);
		while (item_stall);
	endtask

	function automatic void fill_payload(int unsigned n);
		payload_bytes.delete();
		repeat (n)
			payload_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	// Frame the current payload as one record: length, sealed length CRC, payload and
	// sealed payload CRC. The length field may differ from the payload actually
	// carried, which is only used for streams cut short. Either seal can be spoiled
	// by flipping one bit.
	function automatic void frame_record(logic [63:0] len, bit spoil_hdr, bit spoil_trl);
		logic [31:0] c;
		logic [31:0] s;
		frame_bytes.delete();
		c = CRC_INIT;
		for (int i = 0; i < 8; i++) begin
			frame_bytes.push_back(len[8 * i +: 8]);
			c = crc32c_update(c, len[8 * i +: 8]);
		end
		s = seal(c);
		if (spoil_hdr)
			s = s ^ (32'h1 << $urandom_range(0, 31));
		for (int i = 0; i < 4; i++)
			frame_bytes.push_back(s[8 * i +: 8]);
		c = CRC_INIT;
		foreach (payload_bytes[i]) begin
			frame_bytes.push_back(payload_bytes[i]);
			c = crc32c_update(c, payload_bytes[i]);
		end
		s = seal(c);
		if (spoil_trl)
			s = s ^ (32'h1 << $urandom_range(0, 31));
		for (int i = 0; i < 4; i++)
			frame_bytes.push_back(s[8 * i +: 8]);
	endfunction

	task automatic send_frame(int unsigned count);
		for (int i = 0; i < count && i < frame_bytes.size(); i++)
			push_stream_byte(frame_bytes[i], 1'b0);
	endtask

	// Mostly short records, some empty, a few long ones.
	function automatic int unsigned pick_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 0;
		if (r < 80)
			return $urandom_range(1, 16);
		if (r < 97)
			return $urandom_range(17, 64);
		return $urandom_range(65, 300);
	endfunction

	// An empty record, then a two-byte record carrying both byte extremes.
	task automatic test_directed_records();
		payload_bytes.delete();
		frame_record(64'd0, 1'b0, 1'b0);
		send_frame(frame_bytes.size());
		payload_bytes = '{8'h00, 8'hff};
		frame_record(64'd2, 1'b0, 1'b0);
		send_frame(frame_bytes.size());
	endtask

	// Well-formed records with random content under one idling profile.
	task automatic test_random_records(int unsigned gap, int unsigned stall, int unsigned target);
		int unsigned sent;
		int unsigned n;
		gap_pct = gap;
		stall_pct = stall;
		sent = 0;
		while (sent < target) begin
			n = pick_length();
			fill_payload(n);
			frame_record(64'(n), 1'b0, 1'b0);
			send_frame(frame_bytes.size());
			sent += frame_bytes.size();
		end
	endtask

	// The block stops for good on its first ending and reset comes only once, so one
	// way of ending the stream is drawn per run.
	task automatic test_stream_end();
		int unsigned ending;
		int unsigned n;
		logic [63:0] huge;
		ending = $urandom_range(0, 6);
		case (ending)
			0: begin
				// Clean end right at a record boundary.
				push_stream_byte(8'($urandom_range(0, 255)), 1'b1);
			end
			1: begin
				// Stream cut inside the header: a partial length is reported.
				fill_payload(pick_length());
				frame_record(64'(payload_bytes.size()), 1'b0, 1'b0);
				send_frame($urandom_range(1, 11));
				push_stream_byte(8'($urandom_range(0, 255)), 1'b1);
			end
			2: begin
				// Stream cut inside the payload.
				n = $urandom_range(1, 40);
				fill_payload(n);
				frame_record(64'(n), 1'b0, 1'b0);
				send_frame(12 + $urandom_range(0, n - 1));
				push_stream_byte(8'($urandom_range(0, 255)), 1'b1);
			end
			3: begin
				// Stream cut inside the trailer, possibly of an empty record.
				n = $urandom_range(0, 20);
				fill_payload(n);
				frame_record(64'(n), 1'b0, 1'b0);
				send_frame(12 + n + $urandom_range(0, 3));
				push_stream_byte(8'($urandom_range(0, 255)), 1'b1);
			end
			4: begin
				// Corrupted length check.
				fill_payload(pick_length());
				frame_record(64'(payload_bytes.size()), 1'b1, 1'b0);
				send_frame(12);
			end
			5: begin
				// Corrupted payload check.
				fill_payload(pick_length());
				frame_record(64'(payload_bytes.size()), 1'b0, 1'b1);
				send_frame(frame_bytes.size());
			end
			default: begin
				// A huge length that the stream cannot finish, cut in its payload.
				huge = $urandom_range(0, 1) ? '1 : ({$urandom, $urandom} | 64'h8000_0000_0000_0000);
				n = $urandom_range(1, 20);
				fill_payload(n);
				frame_record(huge, 1'b0, 1'b0);
				send_frame(12 + n);
				push_stream_byte(8'($urandom_range(0, 255)), 1'b1);
			end
		endcase
	endtask

	// Once stopped, bytes and ends alike are taken and dropped.
	task automatic test_dropped_after_stop();
		repeat (12)
			push_stream_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
	endtask

	initial begin
		int unsigned guard;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender idles little and the receiver much, then the other way round, then
		// both run flat out.
		test_directed_records();
		test_random_records(8, 48, 600);
		test_random_records(48, 8, 600);
		test_random_records(0, 0, 600);
		test_stream_end();
		test_dropped_after_stop();
		item_valid <= 1'b0;

		// Let the last results drain, then give stray results a chance to show up.
		guard = 0;
		while (pending_results.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);

		if (pending_results.size() != 0) begin
			$display("%0d expected results never arrived", pending_results.size());
			failures += pending_results.size();
		end
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: record_deframer_masked_crc32c.f
rtl/rdmc_pkg.sv
rtl/record_deframer_masked_crc32c.sv
dv/record_deframer_masked_crc32c_tb.sv
